>>> src/bencode_pkg.sv
// ----------------------------------------------------------------------------
// Bencode parser package
// Shared constants, phase codes, event codes, error codes and stack types.
// ----------------------------------------------------------------------------
package bencode_pkg;

  localparam int unsigned MaxDepth = 512;
  localparam int unsigned LenBits = 32;
  localparam int unsigned LevelW = 10;
  localparam int unsigned StackDepth = MaxDepth + 1;
  localparam int unsigned StackAddrW = $clog2(StackDepth);

  typedef enum logic [3:0] {
    PH_VALUE     = 4'd0,
    PH_INT_START = 4'd1,
    PH_INT_NEG   = 4'd2,
    PH_INT_DIG   = 4'd3,
    PH_LEN       = 4'd4,
    PH_PAYLOAD   = 4'd5,
    PH_DONE      = 4'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_LIST = 2'd1,
    KIND_DICT = 2'd2
  } kind_t;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_LIST = 3'd1;
  localparam logic [2:0] EV_DICT = 3'd2;
  localparam logic [2:0] EV_CLOSE = 3'd3;
  localparam logic [2:0] EV_INT = 3'd4;
  localparam logic [2:0] EV_STRLEN = 3'd5;
  localparam logic [2:0] EV_PAYLOAD = 3'd6;
  localparam logic [2:0] EV_ERROR = 3'd7;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_BYTE = 3'd1;
  localparam logic [2:0] ERR_FORM = 3'd2;
  localparam logic [2:0] ERR_OVER = 3'd3;
  localparam logic [2:0] ERR_DEEP = 3'd4;
  localparam logic [2:0] ERR_TRUNC = 3'd5;
  localparam logic [2:0] ERR_TRAIL = 3'd6;

  localparam logic [0:0] REG_DEPTH_LIMIT = 1'd0;

  // Stack write request from the parser to the stack memory.
  typedef struct packed {
    logic                  en;
    logic [StackAddrW-1:0] addr;
    kind_t                 kind;
  } stack_wr_t;

endpackage

>>> src/bencode_stack.sv
// ----------------------------------------------------------------------------
// Bencode kind stack
// Synchronous memory of container kinds with one write and one read port;
// the read data is registered.
// ----------------------------------------------------------------------------
module bencode_stack (
  input  logic                                clk,
  input  bencode_pkg::stack_wr_t              wr,
  input  logic                                rd_en,
  input  logic [bencode_pkg::StackAddrW-1:0]  rd_addr,
  output bencode_pkg::kind_t                  rd_kind
);

  bencode_pkg::kind_t mem [bencode_pkg::StackDepth];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.kind;
    end
    if (rd_en) begin
      rd_kind <= mem[rd_addr];
    end
  end

endmodule

>>> src/bencode_stream_parser_core.sv
// ----------------------------------------------------------------------------
// Bencode stream parser core
// Checks and tokenizes a bencoded buffer one byte per transfer.
// ----------------------------------------------------------------------------
// The result of an input transfer is held in the output register from the next cycle.
// Throughput: one byte per cycle while the output is not held back; the kind of the
// enclosing container is kept in a register and refilled from the stack memory, read ahead of need.
// A closing byte uses the entry below the top, which was read on the previous byte.
// Reset clears the parse state and sets depth_limit to 512; the stack memory is
// not cleared, since every entry is written before its value is relied on.
module bencode_stream_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:2]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        valid,
  output logic        ready,
  input  logic [7:0]  byte_req,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic signed [63:0] value,
  output logic [7:0]  payload_byte,
  output logic        is_key,
  output logic [9:0]  level,
  output logic        done_res,
  output logic        error,
  output logic [2:0]  error_code
);

  localparam int unsigned AW = bencode_pkg::StackAddrW;
  localparam int unsigned LW = bencode_pkg::LevelW;

  logic [LW-1:0] depth_limit;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bencode_pkg::REG_DEPTH_LIMIT) ?
                  {{(32-LW){1'b0}}, depth_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= LW'(512);
    end else if (psel && penable && pwrite &&
                 paddr[2] == bencode_pkg::REG_DEPTH_LIMIT) begin
      depth_limit <= pwdata[LW-1:0];
    end
  end

  // Parse state.
  bencode_pkg::phase_t phase, phase_next;
  logic [LW-1:0] nest, nest_next;
  logic [63:0]   mag, mag_next;
  logic          neg, neg_next;
  logic          zero_first, zero_first_next;
  logic [bencode_pkg::LenBits-1:0] left, left_next;
  logic          key_pending, key_pending_next;
  logic [2:0]    err, err_next;
  // Kind of the top container (register) and of the one below it (from memory).
  bencode_pkg::kind_t top_kind, top_kind_next;
  bencode_pkg::kind_t below_kind;

  logic accept;
  assign ready = !out_valid || out_ready;
  assign accept = valid && ready;

  bencode_pkg::stack_wr_t wr;
  logic [AW-1:0] rd_addr;

  bencode_stack u_stack (
    .clk    (clk),
    .wr     (wr),
    .rd_en  (accept),
    .rd_addr(rd_addr),
    .rd_kind(below_kind)
  );

  logic [2:0]  ev;
  logic [63:0] val;
  logic [7:0]  pb;
  logic        ik;
  logic [2:0]  fail;
  logic        close, vdone, vdone_key;

  logic [LW-1:0] lim;
  logic          dict, is_dig;
  logic [3:0]    d;
  logic [63:0]   top_val, mul10, sum;
  logic [64:0]   prod;
  logic          ovf;

  assign lim = (depth_limit > LW'(bencode_pkg::MaxDepth)) ?
               LW'(bencode_pkg::MaxDepth) : depth_limit;
  assign dict = (nest != '0) && (top_kind == bencode_pkg::KIND_DICT);
  assign is_dig = (byte_req >= 8'd48) && (byte_req <= 8'd57);
  assign d = 4'(byte_req - 8'd48);

  // mag*10 + d with overflow detection against the limit for this number.
  always_comb begin
    top_val = (phase == bencode_pkg::PH_LEN) ?
              64'({bencode_pkg::LenBits{1'b1}}) :
              (neg ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF);
    mul10 = {mag[60:0], 3'b000} + {mag[62:0], 1'b0};
    prod = {1'b0, mul10} + 65'(d);
    ovf = (mag[63:60] != 4'd0) || (mag > 64'h1999999999999999) ||
          prod[64] || (prod[63:0] > top_val);
    sum = prod[63:0];
  end

  always_comb begin
    phase_next = phase;
    nest_next = nest;
    mag_next = mag;
    neg_next = neg;
    zero_first_next = zero_first;
    left_next = left;
    key_pending_next = key_pending;
    err_next = err;
    top_kind_next = top_kind;
    wr = '{en: 1'b0, addr: AW'(nest), kind: bencode_pkg::KIND_LIST};
    ev = bencode_pkg::EV_NONE;
    val = '0;
    pb = '0;
    ik = 1'b0;
    fail = bencode_pkg::ERR_NONE;
    close = 1'b0;
    vdone = 1'b0;
    vdone_key = 1'b0;

    if (err == bencode_pkg::ERR_NONE) begin
      unique case (phase)
        bencode_pkg::PH_VALUE: begin
          if (dict && key_pending) begin
            if (byte_req == 8'd101) begin
              close = 1'b1;
            end else if (is_dig) begin
              mag_next = 64'(d);
              zero_first_next = (d == 4'd0);
              phase_next = bencode_pkg::PH_LEN;
            end else begin
              fail = bencode_pkg::ERR_BYTE;
            end
          end else if (byte_req == 8'd101 && nest != '0 && !dict) begin
            close = 1'b1;
          end else if (nest > lim) begin
            fail = bencode_pkg::ERR_DEEP;
          end else if (byte_req == 8'd108 || byte_req == 8'd100) begin
            wr.en = 1'b1;
            wr.kind = (byte_req == 8'd108) ? bencode_pkg::KIND_LIST :
                                             bencode_pkg::KIND_DICT;
            top_kind_next = wr.kind;
            nest_next = nest + LW'(1);
            ev = (byte_req == 8'd108) ? bencode_pkg::EV_LIST : bencode_pkg::EV_DICT;
            if (byte_req == 8'd100) begin
              key_pending_next = 1'b1;
            end
          end else if (byte_req == 8'd105) begin
            mag_next = '0;
            neg_next = 1'b0;
            zero_first_next = 1'b0;
            phase_next = bencode_pkg::PH_INT_START;
          end else if (is_dig) begin
            mag_next = 64'(d);
            zero_first_next = (d == 4'd0);
            phase_next = bencode_pkg::PH_LEN;
          end else begin
            fail = bencode_pkg::ERR_BYTE;
          end
        end
        bencode_pkg::PH_INT_START, bencode_pkg::PH_INT_NEG: begin
          if (byte_req == 8'd45 && phase == bencode_pkg::PH_INT_START) begin
            neg_next = 1'b1;
            phase_next = bencode_pkg::PH_INT_NEG;
          end else if (byte_req == 8'd101) begin
            fail = bencode_pkg::ERR_FORM;
          end else if (is_dig) begin
            if (neg && d == 4'd0) begin
              fail = bencode_pkg::ERR_FORM;
            end else begin
              mag_next = 64'(d);
              zero_first_next = (d == 4'd0);
              phase_next = bencode_pkg::PH_INT_DIG;
            end
          end else begin
            fail = bencode_pkg::ERR_BYTE;
          end
        end
        bencode_pkg::PH_INT_DIG: begin
          if (is_dig) begin
            if (zero_first) begin
              fail = bencode_pkg::ERR_FORM;
            end else if (ovf) begin
              fail = bencode_pkg::ERR_OVER;
            end else begin
              mag_next = sum;
            end
          end else if (byte_req == 8'd101) begin
            ev = bencode_pkg::EV_INT;
            val = neg ? (64'd0 - mag) : mag;
            vdone = 1'b1;
          end else begin
            fail = bencode_pkg::ERR_BYTE;
          end
        end
        bencode_pkg::PH_LEN: begin
          if (is_dig) begin
            if (zero_first) begin
              fail = bencode_pkg::ERR_FORM;
            end else if (ovf) begin
              fail = bencode_pkg::ERR_OVER;
            end else begin
              mag_next = sum;
            end
          end else if (byte_req == 8'd58) begin
            ev = bencode_pkg::EV_STRLEN;
            val = mag;
            ik = dict && key_pending;
            left_next = mag[bencode_pkg::LenBits-1:0];
            if (mag == '0) begin
              vdone = 1'b1;
              vdone_key = ik;
            end else begin
              phase_next = bencode_pkg::PH_PAYLOAD;
            end
          end else begin
            fail = bencode_pkg::ERR_BYTE;
          end
        end
        bencode_pkg::PH_PAYLOAD: begin
          ev = bencode_pkg::EV_PAYLOAD;
          pb = byte_req;
          ik = dict && key_pending;
          left_next = left - bencode_pkg::LenBits'(1);
          if (left == bencode_pkg::LenBits'(1)) begin
            vdone = 1'b1;
            vdone_key = ik;
          end
        end
        bencode_pkg::PH_DONE: fail = bencode_pkg::ERR_TRAIL;
        default: fail = bencode_pkg::ERR_BYTE;
      endcase

      if (close) begin
        nest_next = nest - LW'(1);
        ev = bencode_pkg::EV_CLOSE;
        top_kind_next = below_kind;
        if (nest_next == '0) begin
          phase_next = bencode_pkg::PH_DONE;
        end else begin
          phase_next = bencode_pkg::PH_VALUE;
          if (below_kind == bencode_pkg::KIND_DICT) begin
            key_pending_next = 1'b1;
          end
        end
      end
      if (vdone) begin
        if (nest == '0) begin
          phase_next = bencode_pkg::PH_DONE;
        end else begin
          phase_next = bencode_pkg::PH_VALUE;
          if (dict) begin
            key_pending_next = !vdone_key;
          end
        end
      end
      if (fail == bencode_pkg::ERR_NONE && last && phase_next != bencode_pkg::PH_DONE) begin
        fail = bencode_pkg::ERR_TRUNC;
      end
      if (fail != bencode_pkg::ERR_NONE) begin
        err_next = fail;
        ev = bencode_pkg::EV_ERROR;
        val = '0;
        pb = '0;
        ik = 1'b0;
      end
    end
  end

  // Prefetch the entry below the new top: after this byte the top is at
  // nest_next-1, so the entry below lies at nest_next-2.
  assign rd_addr = (nest_next >= LW'(2)) ? AW'(nest_next - LW'(2)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= bencode_pkg::PH_VALUE;
      nest <= '0;
      mag <= '0;
      neg <= 1'b0;
      zero_first <= 1'b0;
      left <= '0;
      key_pending <= 1'b0;
      err <= bencode_pkg::ERR_NONE;
      top_kind <= bencode_pkg::KIND_NONE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        out_valid <= 1'b1;
        event_res <= ev;
        value <= val;
        payload_byte <= pb;
        is_key <= ik;
        level <= nest_next;
        done_res <= last && err_next == bencode_pkg::ERR_NONE &&
                    phase_next == bencode_pkg::PH_DONE;
        error <= err_next != bencode_pkg::ERR_NONE;
        error_code <= err_next;
        if (last) begin
          phase <= bencode_pkg::PH_VALUE;
          nest <= '0;
          mag <= '0;
          neg <= 1'b0;
          zero_first <= 1'b0;
          left <= '0;
          key_pending <= 1'b0;
          err <= bencode_pkg::ERR_NONE;
          top_kind <= bencode_pkg::KIND_NONE;
        end else begin
          phase <= phase_next;
          nest <= nest_next;
          mag <= mag_next;
          neg <= neg_next;
          zero_first <= zero_first_next;
          left <= left_next;
          key_pending <= key_pending_next;
          err <= err_next;
          top_kind <= top_kind_next;
        end
      end
    end
  end

endmodule

>>> verif/tb_bencode_stream_parser_core.sv
// ----------------------------------------------------------------------------
// Bencode stream parser core testbench
// Feeds directed and randomly generated bencoded buffers through the core,
// with random idle bursts on both sides and one long output hold, predicts
// every result in a behavioral parser and compares each transfer field by field.
// ----------------------------------------------------------------------------
module tb_bencode_stream_parser_core;

  localparam int CycleLimit = 300000;

  typedef struct {
    logic [7:0] b;
    logic       lst;
  } byte_item_t;

  typedef struct {
    logic [2:0]  ev;
    logic [63:0] val;
    logic [7:0]  pb;
    logic        ik;
    logic [9:0]  lvl;
    logic        dn;
    logic        er;
    logic [2:0]  ec;
  } token_t;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:2]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        valid, ready;
  logic [7:0]  byte_req;
  logic        last;
  logic        out_valid, out_ready;
  logic [2:0]  event_res;
  logic signed [63:0] value;
  logic [7:0]  payload_byte;
  logic        is_key;
  logic [9:0]  level;
  logic        done_res, error;
  logic [2:0]  error_code;

  bencode_stream_parser_core dut (.*);

  byte_item_t  byte_q[$];
  token_t      token_q[$];
  logic [7:0]  text_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          quiet = 0;
  bit          hold_go = 0;

  // Behavioral parser state.
  bencode_pkg::phase_t ph;
  bencode_pkg::kind_t  kinds[bencode_pkg::StackDepth];
  int          nest;
  logic [63:0] mag;
  bit          neg;
  bit          zero_first;
  logic [63:0] left;
  bit          key_wait;
  logic [2:0]  first_err;
  logic [9:0]  depth_cfg;

  function automatic void clear_parser();
    ph = bencode_pkg::PH_VALUE;
    nest = 0;
    mag = '0;
    neg = 0;
    zero_first = 0;
    left = '0;
    key_wait = 0;
    first_err = bencode_pkg::ERR_NONE;
  endfunction

  function automatic bit in_dict();
    return nest > 0 && kinds[nest-1] == bencode_pkg::KIND_DICT;
  endfunction

  function automatic void value_closed(bit was_key);
    if (nest == 0) begin
      ph = bencode_pkg::PH_DONE;
    end else begin
      ph = bencode_pkg::PH_VALUE;
      if (in_dict()) key_wait = !was_key;
    end
  endfunction

  function automatic token_t parse_byte(logic [7:0] b, logic lst);
    token_t      t;
    logic [2:0]  fail;
    logic [63:0] d;
    logic [63:0] top;
    int          lim;
    bit          digit;
    bit          key;
    bit          dict;
    t = '{bencode_pkg::EV_NONE, 64'd0, 8'd0, 1'b0, 10'd0, 1'b0, 1'b0,
          bencode_pkg::ERR_NONE};
    fail = bencode_pkg::ERR_NONE;
    d = 64'(b) - 64'd48;
    digit = b >= "0" && b <= "9";
    lim = depth_cfg > bencode_pkg::MaxDepth ? bencode_pkg::MaxDepth : depth_cfg;
    if (first_err == bencode_pkg::ERR_NONE) begin
      case (ph)
        bencode_pkg::PH_VALUE: begin
          dict = in_dict();
          if (dict && key_wait) begin
            if (b == "e") begin
              nest--;
              t.ev = bencode_pkg::EV_CLOSE;
              value_closed(0);
            end else if (digit) begin
              mag = d;
              zero_first = d == 0;
              ph = bencode_pkg::PH_LEN;
            end else begin
              fail = bencode_pkg::ERR_BYTE;
            end
          end else if (b == "e" && nest > 0 && !dict) begin
            nest--;
            t.ev = bencode_pkg::EV_CLOSE;
            value_closed(0);
          end else if (nest > lim) begin
            fail = bencode_pkg::ERR_DEEP;
          end else if (b == "l" || b == "d") begin
            kinds[nest] = b == "l" ? bencode_pkg::KIND_LIST : bencode_pkg::KIND_DICT;
            nest++;
            t.ev = b == "l" ? bencode_pkg::EV_LIST : bencode_pkg::EV_DICT;
            if (b == "d") key_wait = 1;
            ph = bencode_pkg::PH_VALUE;
          end else if (b == "i") begin
            mag = '0;
            neg = 0;
            zero_first = 0;
            ph = bencode_pkg::PH_INT_START;
          end else if (digit) begin
            mag = d;
            zero_first = d == 0;
            ph = bencode_pkg::PH_LEN;
          end else begin
            fail = bencode_pkg::ERR_BYTE;
          end
        end
        bencode_pkg::PH_INT_START, bencode_pkg::PH_INT_NEG: begin
          if (b == "-" && ph == bencode_pkg::PH_INT_START) begin
            neg = 1;
            ph = bencode_pkg::PH_INT_NEG;
          end else if (b == "e") begin
            fail = bencode_pkg::ERR_FORM;
          end else if (digit) begin
            if (neg && d == 0) begin
              fail = bencode_pkg::ERR_FORM;
            end else begin
              mag = d;
              zero_first = d == 0;
              ph = bencode_pkg::PH_INT_DIG;
            end
          end else begin
            fail = bencode_pkg::ERR_BYTE;
          end
        end
        bencode_pkg::PH_INT_DIG: begin
          if (digit) begin
            top = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            if (zero_first) fail = bencode_pkg::ERR_FORM;
            else if (mag > (top - d) / 10) fail = bencode_pkg::ERR_OVER;
            else mag = mag * 10 + d;
          end else if (b == "e") begin
            t.ev = bencode_pkg::EV_INT;
            t.val = neg ? -mag : mag;
            value_closed(0);
          end else begin
            fail = bencode_pkg::ERR_BYTE;
          end
        end
        bencode_pkg::PH_LEN: begin
          top = (64'd1 << bencode_pkg::LenBits) - 1;
          if (digit) begin
            if (zero_first) fail = bencode_pkg::ERR_FORM;
            else if (mag > (top - d) / 10) fail = bencode_pkg::ERR_OVER;
            else mag = mag * 10 + d;
          end else if (b == ":") begin
            key = in_dict() && key_wait;
            t.ev = bencode_pkg::EV_STRLEN;
            t.val = mag;
            t.ik = key;
            left = mag;
            if (left == 0) value_closed(key);
            else ph = bencode_pkg::PH_PAYLOAD;
          end else begin
            fail = bencode_pkg::ERR_BYTE;
          end
        end
        bencode_pkg::PH_PAYLOAD: begin
          key = in_dict() && key_wait;
          t.ev = bencode_pkg::EV_PAYLOAD;
          t.pb = b;
          t.ik = key;
          left--;
          if (left == 0) value_closed(key);
        end
        bencode_pkg::PH_DONE: fail = bencode_pkg::ERR_TRAIL;
        default: fail = bencode_pkg::ERR_BYTE;
      endcase
      if (fail == bencode_pkg::ERR_NONE && lst && ph != bencode_pkg::PH_DONE)
        fail = bencode_pkg::ERR_TRUNC;
      if (fail != bencode_pkg::ERR_NONE) begin
        first_err = fail;
        t.ev = bencode_pkg::EV_ERROR;
        t.val = '0;
        t.pb = '0;
        t.ik = 0;
      end
    end
    t.lvl = nest[9:0];
    t.dn = lst && first_err == bencode_pkg::ERR_NONE && ph == bencode_pkg::PH_DONE;
    t.er = first_err != bencode_pkg::ERR_NONE;
    t.ec = first_err;
    if (lst) clear_parser();
    return t;
  endfunction

  // Buffer construction helpers.
  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void add_string(int n);
    add_text($sformatf("%0d:", n));
    for (int i = 0; i < n; i++) text_q.push_back(8'($urandom));
  endfunction

  function automatic longint pick_int();
    case ($urandom_range(0, 6))
      0: return longint'(64'h8000_0000_0000_0000);
      1: return longint'(64'h7fff_ffff_ffff_ffff);
      2: return longint'({$urandom, $urandom});
      3: return longint'(int'($urandom));
      4: return -longint'($urandom_range(1, 99));
      default: return longint'($urandom_range(0, 12));
    endcase
  endfunction

  function automatic int pick_len();
    return $urandom_range(0, 7) == 0 ? $urandom_range(5, 12) : $urandom_range(0, 4);
  endfunction

  function automatic void add_value(int d);
    int n;
    case (d >= 5 ? $urandom_range(0, 1) : $urandom_range(0, 3))
      0: add_text($sformatf("i%0de", pick_int()));
      1: add_string(pick_len());
      2: begin
        n = $urandom_range(0, 3);
        add_text("l");
        for (int i = 0; i < n; i++) add_value(d + 1);
        add_text("e");
      end
      default: begin
        n = $urandom_range(0, 3);
        add_text("d");
        for (int i = 0; i < n; i++) begin
          add_string(pick_len());
          add_value(d + 1);
        end
        add_text("e");
      end
    endcase
  endfunction

  // Moves the built text into the transfer queue, flagging its final byte.
  function automatic void send_text();
    foreach (text_q[i]) byte_q.push_back('{text_q[i], i == text_q.size() - 1});
    text_q.delete();
  endfunction

  function automatic void send_literal(string s);
    add_text(s);
    send_text();
  endfunction

  // Mostly well-formed buffers; the rest are cut short, padded, damaged or noise.
  function automatic int send_random_buffer();
    int r, n, sz;
    r = $urandom_range(0, 99);
    if (r < 95) begin
      add_value(0);
      if (r >= 75 && r < 83 && text_q.size() > 1) begin
        n = $urandom_range(1, text_q.size() - 1);
        while (text_q.size() > n) void'(text_q.pop_back());
      end else if (r >= 83 && r < 89) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) text_q.push_back(8'($urandom));
      end else if (r >= 89) begin
        text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom);
      end
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) text_q.push_back(8'($urandom));
    end
    sz = text_q.size();
    send_text();
    return sz;
  endfunction

  function automatic void send_random(int count);
    int sent;
    sent = 0;
    while (sent < count) sent += send_random_buffer();
  endfunction

  task automatic write_depth_limit(logic [9:0] v);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= bencode_pkg::REG_DEPTH_LIMIT;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    depth_cfg = v;
  endtask

  task automatic wait_idle();
    while (byte_q.size() > 0 || valid || token_q.size() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sender: offers bytes from the transfer queue with random idle bursts.
  always @(posedge clk) begin : sender
    byte_item_t it;
    int gap;
    if (rst) begin
      valid <= 0;
      byte_req <= '0;
      last <= 0;
      gap = 0;
    end else begin
      if (valid && ready) token_q.push_back(parse_byte(byte_req, last));
      if (!valid || ready) begin
        if (gap > 0) begin
          gap--;
          valid <= 0;
        end else if (byte_q.size() > 0) begin
          it = byte_q.pop_front();
          valid <= 1;
          byte_req <= it.b;
          last <= it.lst;
          if (!quiet && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 8);
        end else begin
          valid <= 0;
        end
      end
    end
  end

  // Receiver: random stalls, and one long hold so the core backs up.
  always @(posedge clk) begin : receiver
    int stall;
    int hold_cnt;
    if (rst) begin
      out_ready <= 0;
      stall = 0;
      hold_cnt = 0;
    end else if (hold_go && hold_cnt < 300) begin
      hold_cnt++;
      out_ready <= 0;
    end else if (stall > 0) begin
      stall--;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
      if (!quiet && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 8);
    end
  end

  function automatic void report(string field, logic [63:0] exp_v, logic [63:0] act_v);
    mismatches++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
  endfunction

  always @(posedge clk) begin : monitor
    token_t e;
    if (!rst && out_valid && out_ready) begin
      if (token_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transfer, expected none, got event %0d",
                 $time, event_res);
      end else begin
        e = token_q.pop_front();
        if (event_res !== e.ev) report("event_res", e.ev, event_res);
        if (value !== e.val) report("value", e.val, value);
        if (payload_byte !== e.pb) report("payload_byte", e.pb, payload_byte);
        if (is_key !== e.ik) report("is_key", e.ik, is_key);
        if (level !== e.lvl) report("level", e.lvl, level);
        if (done_res !== e.dn) report("done_res", e.dn, done_res);
        if (error !== e.er) report("error", e.er, error);
        if (error_code !== e.ec) report("error_code", e.ec, error_code);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = bencode_pkg::REG_DEPTH_LIMIT;
    pwdata = '0;
    depth_cfg = 10'd512;
    clear_parser();
    repeat (4) @(posedge clk);
    rst <= 0;

    write_depth_limit(10'd512);
    send_literal("i0e");
    send_literal("i-9223372036854775808e");
    send_literal("i9223372036854775807e");
    send_literal("i9223372036854775808e");
    send_literal("i-9223372036854775809e");
    send_literal("i-0e");
    send_literal("i03e");
    send_literal("ie");
    send_literal("i-e");
    send_literal("i1x");
    send_literal("03:abc");
    send_literal("4294967295:a");
    send_literal("4294967296:");
    send_literal("0:");
    send_literal("le");
    send_literal("d1:ai-5ee");
    send_literal("di1ei2ee");
    send_literal("d1:ae");
    send_literal("e");
    send_literal("i1ei2e");
    send_literal("l1:x");
    send_literal("d3:keyl4:spami7eee");
    wait_idle();

    // With a zero limit only top-level values may start.
    write_depth_limit(10'd0);
    send_literal("li1ee");
    send_literal("le");
    send_literal("i5e");
    send_random(100);
    wait_idle();

    write_depth_limit(10'd3);
    send_random(200);
    wait_idle();

    // Nest to the deepest level allowed, then one more opening is too deep.
    write_depth_limit(10'd512);
    for (int i = 0; i < 513; i++) text_q.push_back("l");
    add_text("ll");
    send_text();
    send_random(100);
    wait_idle();

    write_depth_limit(10'd1);
    send_random(150);
    @(negedge clk);
    hold_go = 1;
    wait_idle();

    write_depth_limit(10'd2);
    send_random(100);
    quiet = 1;
    send_random(100);
    wait_idle();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && token_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
src/bencode_pkg.sv
src/bencode_stack.sv
src/bencode_stream_parser_core.sv
verif/tb_bencode_stream_parser_core.sv
